// ===== design/hdwr_pkg.sv =====
`default_nettype none

package hdwr_pkg;

    // Band state codes, as seen on the band_state_out port
    typedef enum logic [2:0] {
        BS_NORMAL    = 3'd0,
        BS_OUTSIDE   = 3'd1,
        BS_SHIFTED   = 3'd2,
        BS_RAMP_UP   = 3'd3,
        BS_RAMP_DOWN = 3'd4
    } t_band_state;

    // Outcome of one pass of the transition rules
    typedef struct packed {
        t_band_state state;
        logic        tripped_high;
        logic        changed;
    } t_pass;

    // Configuration register indexes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_REST_LEVEL      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BAND_HIGH       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BAND_LOW        = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RAMP_UP_WIDTH   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RAMP_DOWN_WIDTH = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE_HIGH    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE_LOW     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SHIFT_MODE      = 3'd7;

    // Upper bound on rule passes per sample
    localparam int MAX_PASSES = 8;

endpackage

`default_nettype wire

// ===== design/hdwr_addsub.sv =====
`default_nettype none

// Shared adder/subtractor used by every arithmetic step of the mapping sequence
module hdwr_addsub #(
    parameter int AW = 35
) (
    input  wire logic [AW-1:0] i_a,
    input  wire logic [AW-1:0] i_b,
    input  wire logic          i_sub,
    output logic      [AW-1:0] o_y
);

    // Add or subtract, wrapping at AW bits
    assign o_y = i_sub ? (i_a - i_b) : (i_a + i_b);

endmodule

`default_nettype wire

// ===== design/hdwr_rules.sv =====
`default_nettype none

// One pass of the band transition rules
module hdwr_rules #(
    parameter int W = 32
) (
    input  wire logic [W-1:0]           i_sample,
    input  wire logic [W-1:0]           i_band_high,
    input  wire logic [W-1:0]           i_band_low,
    input  wire logic [W-1:0]           i_release_high,
    input  wire logic [W-1:0]           i_release_low,
    input  wire logic [W-2:0]           i_ramp_up_width,
    input  wire logic [W-2:0]           i_ramp_down_width,
    input  wire logic                   i_shift_mode,
    input  wire hdwr_pkg::t_band_state  i_state,
    input  wire logic                   i_tripped_high,
    output hdwr_pkg::t_pass             o_pass
);

    logic signed [W:0] s;
    logic signed [W:0] bh;
    logic signed [W:0] bl;
    logic signed [W:0] rh;
    logic signed [W:0] rl;
    logic signed [W:0] ruw;
    logic signed [W:0] rdw;
    logic signed [W:0] w_act;
    logic signed [W:0] rh_deep;
    logic signed [W:0] rl_deep;
    logic signed [W:0] bh_far;
    logic signed [W:0] bl_far;
    logic              above_high;
    logic              below_low;
    logic              release_cross;
    logic              deep;

    // Widen by one bit so that thresholds plus widths cannot wrap
    assign s   = {i_sample[W-1], i_sample};
    assign bh  = {i_band_high[W-1], i_band_high};
    assign bl  = {i_band_low[W-1], i_band_low};
    assign rh  = {i_release_high[W-1], i_release_high};
    assign rl  = {i_release_low[W-1], i_release_low};
    assign ruw = {2'b00, i_ramp_up_width};
    assign rdw = {2'b00, i_ramp_down_width};

    assign w_act   = (i_state == hdwr_pkg::BS_RAMP_UP) ? ruw : rdw;
    assign rh_deep = rh - rdw;
    assign rl_deep = rl + rdw;
    assign bh_far  = bh + w_act;
    assign bl_far  = bl - w_act;

    assign above_high    = s > bh;
    assign below_low     = s < bl;
    assign release_cross = i_tripped_high ? (s < rh) : (s > rl);
    assign deep          = i_tripped_high ? (s < rh_deep) : (s > rl_deep);

    // Pick the next state for the current one
    always_comb begin
        o_pass.state        = i_state;
        o_pass.tripped_high = i_tripped_high;
        o_pass.changed      = 1'b0;
        case (i_state)
            hdwr_pkg::BS_OUTSIDE: begin
                if (release_cross) begin
                    if ((|i_ramp_down_width) && !deep) begin
                        o_pass.state = hdwr_pkg::BS_RAMP_DOWN;
                    end else begin
                        o_pass.state   = hdwr_pkg::BS_NORMAL;
                        o_pass.changed = 1'b1;
                    end
                end
            end
            hdwr_pkg::BS_SHIFTED: begin
                if ((s < bh) && (s > bl)) begin
                    o_pass.state   = hdwr_pkg::BS_NORMAL;
                    o_pass.changed = 1'b1;
                end
            end
            hdwr_pkg::BS_RAMP_UP, hdwr_pkg::BS_RAMP_DOWN: begin
                if (i_tripped_high) begin
                    if (s > bh_far) begin
                        o_pass.state = hdwr_pkg::BS_OUTSIDE;
                    end else if (s < bh) begin
                        o_pass.state   = hdwr_pkg::BS_NORMAL;
                        o_pass.changed = 1'b1;
                    end
                end else begin
                    if (s < bl_far) begin
                        o_pass.state = hdwr_pkg::BS_OUTSIDE;
                    end else if (s > bl) begin
                        o_pass.state   = hdwr_pkg::BS_NORMAL;
                        o_pass.changed = 1'b1;
                    end
                end
            end
            default: begin
                o_pass.state = hdwr_pkg::BS_NORMAL;
                if (above_high || below_low) begin
                    o_pass.changed      = 1'b1;
                    o_pass.tripped_high = above_high;
                    if (i_shift_mode) begin
                        o_pass.state = hdwr_pkg::BS_SHIFTED;
                    end else if (|i_ramp_up_width) begin
                        o_pass.state = hdwr_pkg::BS_RAMP_UP;
                    end else begin
                        o_pass.state = hdwr_pkg::BS_OUTSIDE;
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/hysteretic_deadband_with_ramps.sv =====
`default_nettype none

// Deadband with hysteresis and ramp regions on signed fixed-point samples. One sample is
// taken at a time: the transition rules run one pass a cycle (at most eight passes) until
// the band state settles, and the sample is then mapped to the rest level, itself, a
// shifted value or a linear ramp. All arithmetic of the mapping goes through one shared
// adder. A sample that ends inside, outside or in a transparent block finishes soonest,
// a shifted result later; a ramp result takes longest, set by the bit-serial multiply
// (DATA_WIDTH+1 steps) and the restoring divide (2*DATA_WIDTH+2 steps) through that
// adder. The finished result sits in an output register, so the next sample may be
// accepted while it waits to be taken. Configuration is written by index and must only
// change while the block is idle.
module hysteretic_deadband_with_ramps #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Sample channel
    input  wire logic                           i_sample_valid,
    output logic                                o_sample_ready,
    input  wire logic [DATA_WIDTH-1:0]          i_sample,
    // Result channel
    output logic                                o_result_valid,
    input  wire logic                           i_result_ready,
    output logic      [DATA_WIDTH-1:0]          o_mapped_value,
    output logic      [2:0]                     o_band_state_out,
    output logic                                o_state_changed,
    // Configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [hdwr_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DATA_WIDTH-1:0]          i_cfg_data
);

    localparam int W  = DATA_WIDTH;
    localparam int MW = W + 1;          // magnitude width of multiply operands
    localparam int AW = W + 3;          // width of the shared adder
    localparam int PW = 2 * MW;         // product / quotient width
    localparam int CW = $clog2(PW + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PASS,
        ST_MAP,
        ST_T,
        ST_SHV,
        ST_B,
        ST_A,
        ST_ABSA,
        ST_ABSB,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } t_seq_state;

    // Configuration registers
    logic [W-1:0] r_rest_level;
    logic [W-1:0] r_band_high;
    logic [W-1:0] r_band_low;
    logic [W-2:0] r_ramp_up_width;
    logic [W-2:0] r_ramp_down_width;
    logic [W-1:0] r_release_high;
    logic [W-1:0] r_release_low;
    logic         r_shift_mode;

    // Sequencer and data path
    t_seq_state            r_state;
    hdwr_pkg::t_band_state r_band_state;
    logic                  r_tripped_high;
    logic [W-1:0]          r_s;
    logic                  r_chg;
    logic [CW-1:0]         r_cnt;
    logic                  r_sel;
    logic                  r_neg;
    logic [AW-1:0]         r_t;
    logic [AW-1:0]         r_a;
    logic [AW-1:0]         r_b;
    logic [AW-1:0]         r_v;
    logic [PW-1:0]         r_prod;
    logic [W-2:0]          r_rem;

    // Output register
    logic         r_out_valid;
    logic [W-1:0] r_mapped;
    logic [2:0]   r_state_out;
    logic         r_changed;

    hdwr_pkg::t_pass pass;
    logic [AW-1:0]   alu_a;
    logic [AW-1:0]   alu_b;
    logic            alu_sub;
    logic [AW-1:0]   alu_y;
    logic [AW-1:0]   s_x;
    logic [AW-1:0]   rest_x;
    logic [AW-1:0]   bh_x;
    logic [AW-1:0]   bl_x;
    logic [W-2:0]    w_cur;
    logic [AW-1:0]   w_x;
    logic [W-1:0]    div_rs;
    logic [MW:0]     q_mag;
    logic [AW-1:0]   q_x;
    logic            transparent;
    logic [W-1:0]    v_sat;

    // Rule evaluation
    hdwr_rules #(
        .W (W)
    ) u_rules (
        .i_sample          (r_s),
        .i_band_high       (r_band_high),
        .i_band_low        (r_band_low),
        .i_release_high    (r_release_high),
        .i_release_low     (r_release_low),
        .i_ramp_up_width   (r_ramp_up_width),
        .i_ramp_down_width (r_ramp_down_width),
        .i_shift_mode      (r_shift_mode),
        .i_state           (r_band_state),
        .i_tripped_high    (r_tripped_high),
        .o_pass            (pass)
    );

    // Shared arithmetic unit
    hdwr_addsub #(
        .AW (AW)
    ) u_addsub (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_y   (alu_y)
    );

    // Widened operands
    assign s_x    = {{(AW-W){r_s[W-1]}}, r_s};
    assign rest_x = {{(AW-W){r_rest_level[W-1]}}, r_rest_level};
    assign bh_x   = {{(AW-W){r_band_high[W-1]}}, r_band_high};
    assign bl_x   = {{(AW-W){r_band_low[W-1]}}, r_band_low};
    assign w_cur  = (r_band_state == hdwr_pkg::BS_RAMP_UP) ? r_ramp_up_width
                                                            : r_ramp_down_width;
    assign w_x    = {{(AW-W+1){1'b0}}, w_cur};
    assign div_rs = {r_rem, r_prod[PW-1]};

    // Clamp the quotient at 2^(W+1); anything that large saturates anyway
    assign q_mag = (|r_prod[PW-1:MW]) ? {1'b1, {MW{1'b0}}} : {1'b0, r_prod[MW-1:0]};
    assign q_x   = {{(AW-MW-1){1'b0}}, q_mag};

    assign transparent = !($signed(r_band_low) < $signed(r_band_high));

    // Saturate the mapped value to the output width
    always_comb begin
        if ((&r_v[AW-1:W-1]) || !(|r_v[AW-1:W-1])) begin
            v_sat = r_v[W-1:0];
        end else if (r_v[AW-1]) begin
            v_sat = {1'b1, {(W-1){1'b0}}};
        end else begin
            v_sat = {1'b0, {(W-1){1'b1}}};
        end
    end

    // Steer the shared adder for the current step
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            ST_T: begin
                alu_a   = r_sel ? bh_x : rest_x;
                alu_b   = r_sel ? rest_x : bl_x;
                alu_sub = 1'b1;
            end
            ST_SHV: begin
                alu_a   = s_x;
                alu_b   = r_t;
                alu_sub = r_sel;
            end
            ST_B: begin
                alu_a = r_t;
                alu_b = w_x;
            end
            ST_A: begin
                alu_a   = r_sel ? s_x : bl_x;
                alu_b   = r_sel ? bh_x : s_x;
                alu_sub = 1'b1;
            end
            ST_ABSA: begin
                alu_a   = r_a[AW-1] ? '0 : r_a;
                alu_b   = r_a[AW-1] ? r_a : '0;
                alu_sub = r_a[AW-1];
            end
            ST_ABSB: begin
                alu_a   = r_b[AW-1] ? '0 : r_b;
                alu_b   = r_b[AW-1] ? r_b : '0;
                alu_sub = r_b[AW-1];
            end
            ST_MUL: begin
                alu_a = {{(AW-MW){1'b0}}, r_prod[PW-1:MW]};
                alu_b = r_prod[0] ? {{(AW-MW){1'b0}}, r_b[MW-1:0]} : '0;
            end
            ST_DIV: begin
                alu_a   = {{(AW-W){1'b0}}, div_rs};
                alu_b   = w_x;
                alu_sub = 1'b1;
            end
            ST_FIN: begin
                alu_a   = rest_x;
                alu_b   = q_x;
                alu_sub = !(r_sel ^ r_neg);
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest_level      <= '0;
            r_band_high       <= '0;
            r_band_low        <= '0;
            r_ramp_up_width   <= '0;
            r_ramp_down_width <= '0;
            r_release_high    <= '1;
            r_release_low     <= {{(W-1){1'b0}}, 1'b1};
            r_shift_mode      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hdwr_pkg::REG_REST_LEVEL:      r_rest_level      <= i_cfg_data;
                hdwr_pkg::REG_BAND_HIGH:       r_band_high       <= i_cfg_data;
                hdwr_pkg::REG_BAND_LOW:        r_band_low        <= i_cfg_data;
                hdwr_pkg::REG_RAMP_UP_WIDTH:   r_ramp_up_width   <= i_cfg_data[W-2:0];
                hdwr_pkg::REG_RAMP_DOWN_WIDTH: r_ramp_down_width <= i_cfg_data[W-2:0];
                hdwr_pkg::REG_RELEASE_HIGH:    r_release_high    <= i_cfg_data;
                hdwr_pkg::REG_RELEASE_LOW:     r_release_low     <= i_cfg_data;
                hdwr_pkg::REG_SHIFT_MODE:      r_shift_mode      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer, data path and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_band_state   <= hdwr_pkg::BS_NORMAL;
            r_tripped_high <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            // Drop the result once it has been transferred
            if (r_out_valid && i_result_ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_sample_valid) begin
                        r_s     <= i_sample;
                        r_chg   <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= ST_PASS;
                    end
                end
                ST_PASS: begin
                    if (transparent) begin
                        r_v     <= s_x;
                        r_state <= ST_DONE;
                    end else begin
                        r_band_state   <= pass.state;
                        r_tripped_high <= pass.tripped_high;
                        r_chg          <= r_chg | pass.changed;
                        r_cnt          <= r_cnt + 1'b1;
                        if ((pass.state == r_band_state) ||
                            (r_cnt == CW'(hdwr_pkg::MAX_PASSES - 1))) begin
                            r_state <= ST_MAP;
                        end
                    end
                end
                ST_MAP: begin
                    r_sel <= $signed(r_s) > $signed(r_rest_level);
                    case (r_band_state)
                        hdwr_pkg::BS_NORMAL: begin
                            r_v     <= rest_x;
                            r_state <= ST_DONE;
                        end
                        hdwr_pkg::BS_OUTSIDE: begin
                            r_v     <= s_x;
                            r_state <= ST_DONE;
                        end
                        hdwr_pkg::BS_SHIFTED: begin
                            r_state <= ST_T;
                        end
                        default: begin
                            if (w_cur == '0) begin
                                r_v     <= s_x;
                                r_state <= ST_DONE;
                            end else begin
                                r_state <= ST_T;
                            end
                        end
                    endcase
                end
                ST_T: begin
                    r_t     <= alu_y;
                    r_state <= (r_band_state == hdwr_pkg::BS_SHIFTED) ? ST_SHV : ST_B;
                end
                ST_SHV: begin
                    r_v     <= alu_y;
                    r_state <= ST_DONE;
                end
                ST_B: begin
                    r_b     <= alu_y;
                    r_state <= ST_A;
                end
                ST_A: begin
                    r_a     <= alu_y;
                    r_state <= ST_ABSA;
                end
                ST_ABSA: begin
                    r_neg   <= r_a[AW-1];
                    r_a     <= alu_y;
                    r_state <= ST_ABSB;
                end
                ST_ABSB: begin
                    r_neg   <= r_neg ^ r_b[AW-1];
                    r_b     <= alu_y;
                    r_prod  <= {{MW{1'b0}}, r_a[MW-1:0]};
                    r_cnt   <= '0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    // Shift-and-add, one multiplier bit a cycle
                    r_prod <= {alu_y[MW:0], r_prod[MW-1:1]};
                    if (r_cnt == CW'(MW - 1)) begin
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_state <= ST_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DIV: begin
                    // Restoring division, one quotient bit a cycle
                    if (!alu_y[AW-1]) begin
                        r_rem  <= alu_y[W-2:0];
                        r_prod <= {r_prod[PW-2:0], 1'b1};
                    end else begin
                        r_rem  <= div_rs[W-2:0];
                        r_prod <= {r_prod[PW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(PW - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_v     <= alu_y;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    // Hold until the output register is free
                    if (!r_out_valid || i_result_ready) begin
                        r_out_valid <= 1'b1;
                        r_mapped    <= v_sat;
                        r_state_out <= r_band_state;
                        r_changed   <= r_chg;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_sample_ready   = (r_state == ST_IDLE);
    assign o_result_valid   = r_out_valid;
    assign o_mapped_value   = r_mapped;
    assign o_band_state_out = r_state_out;
    assign o_state_changed  = r_changed;

endmodule

`default_nettype wire
